>>> src/assert_macros.svh
// Assertion macros shared by the double-ended priority queue RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> src/depq_pkg.sv
// Types and constants of the double-ended priority queue.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package depq_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_W    = 32;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int OCC_W    = 7;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [COUNT_W-1:0]      count_type;

   typedef enum logic [1:0] {
      ACT_INSERT     = 2'd0,
      ACT_REMOVE_MAX = 2'd1,
      ACT_REMOVE_MIN = 2'd2,
      ACT_NONE       = 2'd3
   } action_type;

   typedef enum logic {
      S_IDLE,
      S_REPORT
   } state_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic       strobe;
      action_type act;
      key_type    key;
   } cell_cmd_type;

endpackage

>>> src/depq_cell.sv
// One cell of the sorted key chain: holds one key and trades it with its neighbors.
// Depends on depq_pkg.
`timescale 1ns / 1ps
module depq_cell (
   input  logic                  clock,
   input  depq_pkg::cell_cmd_type cmd,
   input  logic                  occ,
   input  depq_pkg::key_type     left_key,
   input  logic                  left_shift,
   input  depq_pkg::key_type     right_key,
   output depq_pkg::key_type     key_q,
   output logic                  shift
);
   import depq_pkg::*;

   key_type key_ff;
   key_type key_in;

   // A new key lands before every stored key that is strictly greater, so equal
   // keys keep their arrival order. Empty cells always count as greater.
   assign shift = !occ || (cmd.key < key_ff);
   assign key_q = key_ff;

   always_comb begin
      key_in = key_ff;
      if (cmd.strobe) begin
         unique case (cmd.act)
            ACT_INSERT: begin
               priority if (left_shift) key_in = left_key;
               else if (shift)          key_in = cmd.key;
               else                     key_in = key_ff;
            end
            ACT_REMOVE_MIN:           key_in = right_key;
            ACT_REMOVE_MAX, ACT_NONE: key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

>>> src/depq_chain.sv
// Row of CAPACITY sorted key cells plus the selector for the largest stored key.
// Depends on depq_pkg and depq_cell.
`timescale 1ns / 1ps
module depq_chain (
   input  logic                   clock,
   input  depq_pkg::cell_cmd_type cmd,
   input  depq_pkg::count_type    count,
   output depq_pkg::key_type      top_key,
   output depq_pkg::key_type      bottom_key
);
   import depq_pkg::*;

   key_type             keys  [CAPACITY];
   logic [CAPACITY-1:0] occ;
   logic [CAPACITY-1:0] shifts;
   logic [CAPACITY-1:0] is_top;
   key_type             masked [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      key_type lk;
      key_type rk;
      logic    ls;

      assign occ[i] = count > COUNT_W'(i);
      if (i == 0) begin : g_first
         assign lk = keys[0];
         assign ls = 1'b0;
      end else begin : g_mid
         assign lk = keys[i-1];
         assign ls = shifts[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign rk        = keys[i];
         assign is_top[i] = occ[i];
      end else begin : g_inner
         assign rk        = keys[i+1];
         assign is_top[i] = occ[i] && !occ[i+1];
      end
      assign masked[i] = is_top[i] ? keys[i] : '0;

      depq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occ        (occ[i]),
         .left_key   (lk),
         .left_shift (ls),
         .right_key  (rk),
         .key_q      (keys[i]),
         .shift      (shifts[i])
      );
   end

   // At most one cell is the top one, so an OR over masked keys selects it.
   always_comb begin
      top_key = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         top_key = top_key | masked[i];
      end
   end

   assign bottom_key = keys[0];

endmodule

>>> src/double_ended_priority_queue_unit.sv
// Top level of the double-ended priority queue: sequencer, key count and result register.
// Depends on depq_pkg, depq_chain and assert_macros.svh.
//
//   channel | ports                         | direction
//   --------+-------------------------------+----------
//   request | req_valid/stall, action, key  | in
//   result  | rsp_valid/stall, six fields   | out
//
// For each request the accept edge updates the cell chain; in the report state the result
// register is then loaded from the new chain contents once the previous result is taken.
// A request may be accepted while the previous result still waits in rsp_*.
// Reset clears the count and the sequencer; cell contents stay unknown until written.
// A stalled result holds the sequencer in its report cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module double_ended_priority_queue_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_action,
   input  depq_pkg::key_type   req_key_in,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output depq_pkg::key_type   rsp_max_key,
   output depq_pkg::key_type   rsp_min_key,
   output logic [depq_pkg::OCC_W-1:0] rsp_occupancy,
   output depq_pkg::key_type   rsp_removed_key,
   output logic                rsp_removed_valid,
   output logic                rsp_overflow
);
   import depq_pkg::*;

   state_type    state_ff, state_in;
   count_type    count_ff, count_in;
   key_type      removed_ff, removed_in;
   logic         removed_valid_ff, removed_valid_in;
   logic         overflow_ff, overflow_in;
   logic         rsp_valid_ff, rsp_valid_in;
   key_type      max_ff, min_ff, rkey_ff;
   logic [OCC_W-1:0] occ_ff;
   logic         rval_ff, ovf_ff;

   cell_cmd_type cmd;
   action_type   act;
   key_type      top_key, bottom_key;
   logic         accept, load, empty, full;

   assign act    = action_type'(req_action);
   assign accept = req_valid && !req_stall;
   assign empty  = count_ff == '0;
   assign full   = count_ff == COUNT_W'(CAPACITY);
   assign load   = (state_ff == S_REPORT) && (!rsp_valid_ff || !rsp_stall);

   depq_chain u_chain (
      .clock      (clock),
      .cmd        (cmd),
      .count      (count_ff),
      .top_key    (top_key),
      .bottom_key (bottom_key)
   );

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      removed_in       = removed_ff;
      removed_valid_in = removed_valid_ff;
      overflow_in      = overflow_ff;
      req_stall        = state_ff != S_IDLE;
      cmd.strobe       = 1'b0;
      cmd.act          = act;
      cmd.key          = req_key_in;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in         = S_REPORT;
               removed_in       = '0;
               removed_valid_in = 1'b0;
               overflow_in      = 1'b0;
               unique case (act)
                  ACT_INSERT: begin
                     if (full) begin
                        overflow_in = 1'b1;
                     end else begin
                        cmd.strobe = 1'b1;
                        count_in   = count_ff + COUNT_W'(1);
                     end
                  end
                  ACT_REMOVE_MAX: begin
                     if (!empty) begin
                        removed_in       = top_key;
                        removed_valid_in = 1'b1;
                        count_in         = count_ff - COUNT_W'(1);
                     end
                  end
                  ACT_REMOVE_MIN: begin
                     if (!empty) begin
                        cmd.strobe       = 1'b1;
                        removed_in       = bottom_key;
                        removed_valid_in = 1'b1;
                        count_in         = count_ff - COUNT_W'(1);
                     end
                  end
                  ACT_NONE: begin
                     count_in = count_ff;
                  end
               endcase
            end
         end
         S_REPORT: begin
            if (load) state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (load)                 rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      else                               rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      removed_ff       <= removed_in;
      removed_valid_ff <= removed_valid_in;
      overflow_ff      <= overflow_in;
      if (load) begin
         max_ff  <= empty ? '0 : top_key;
         min_ff  <= empty ? '0 : bottom_key;
         occ_ff  <= OCC_W'(count_ff);
         rkey_ff <= removed_ff;
         rval_ff <= removed_valid_ff;
         ovf_ff  <= overflow_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_max_key       = max_ff;
   assign rsp_min_key       = min_ff;
   assign rsp_occupancy     = occ_ff;
   assign rsp_removed_key   = rkey_ff;
   assign rsp_removed_valid = rval_ff;
   assign rsp_overflow      = ovf_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= COUNT_W'(CAPACITY))
   `ASSERT_NEXT(a_accept_reports, clock, reset, accept, state_ff == S_REPORT)
   `ASSERT_IMPLIES(a_overflow_full, clock, reset, load && overflow_ff, full)
   `ASSERT_IMPLIES(a_flags_exclusive, clock, reset, rsp_valid_ff, !(rval_ff && ovf_ff))
   `ASSERT_NEXT(a_count_steady, clock, reset, state_ff == S_REPORT, $stable(count_ff))

endmodule

>>> tb/tb_double_ended_priority_queue_unit.sv
// Self-checking testbench for double_ended_priority_queue_unit: inserts and removals are
// driven and checked against a sorted-list model of the queue.
// Depends on depq_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_double_ended_priority_queue_unit;
   import depq_pkg::*;

   localparam int CYCLE_LIMIT   = 100000;
   localparam int RANDOM_COUNT  = 1050;
   localparam int HOLD_START    = 400;
   localparam int HOLD_LENGTH   = 200;
   localparam int PHASE_LENGTH  = 90;

   typedef struct {
      action_type act;
      key_type    key;
   } depq_request_type;

   typedef struct {
      key_type          max_key;
      key_type          min_key;
      logic [OCC_W-1:0] occupancy;
      key_type          removed_key;
      logic             removed_valid;
      logic             overflow;
   } depq_report_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_action = ACT_NONE;
   key_type             req_key_in = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   key_type             rsp_max_key;
   key_type             rsp_min_key;
   logic [OCC_W-1:0]    rsp_occupancy;
   key_type             rsp_removed_key;
   logic                rsp_removed_valid;
   logic                rsp_overflow;

   depq_request_type request_backlog[$];
   depq_report_type  pending_reports[$];
   key_type          sorted_keys[$];

   int total_requests = 0;
   int accepted_requests = 0;
   int error_count = 0;
   int cycle_count = 0;
   int hold_cycles = 0;
   bit hold_used = 1'b0;
   int dropped_inserts = 0;
   int empty_removals = 0;
   int peak_occupancy = 0;

   double_ended_priority_queue_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_key_in        (req_key_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_max_key       (rsp_max_key),
      .rsp_min_key       (rsp_min_key),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_removed_key   (rsp_removed_key),
      .rsp_removed_valid (rsp_removed_valid),
      .rsp_overflow      (rsp_overflow)
   );

   always #6 clock = ~clock;

   // Applies one request to the sorted key list and returns the report it produces.
   function automatic depq_report_type depq_update(input logic [1:0] act, input key_type key);
      depq_report_type rep;
      int pos;
      rep.removed_key   = '0;
      rep.removed_valid = 1'b0;
      rep.overflow      = 1'b0;
      case (act)
         ACT_INSERT: begin
            if (sorted_keys.size() >= CAPACITY) begin
               rep.overflow = 1'b1;
               dropped_inserts++;
            end else begin
               // Equal keys go after the ones already stored.
               pos = sorted_keys.size();
               while (pos > 0 && key < sorted_keys[pos-1])
                  pos--;
               sorted_keys.insert(pos, key);
            end
         end
         ACT_REMOVE_MAX: begin
            if (sorted_keys.size() > 0) begin
               rep.removed_key   = sorted_keys.pop_back();
               rep.removed_valid = 1'b1;
            end else begin
               empty_removals++;
            end
         end
         ACT_REMOVE_MIN: begin
            if (sorted_keys.size() > 0) begin
               rep.removed_key   = sorted_keys.pop_front();
               rep.removed_valid = 1'b1;
            end else begin
               empty_removals++;
            end
         end
         default: ;
      endcase
      if (sorted_keys.size() > 0) begin
         rep.max_key = sorted_keys[sorted_keys.size()-1];
         rep.min_key = sorted_keys[0];
      end else begin
         rep.max_key = '0;
         rep.min_key = '0;
      end
      rep.occupancy = OCC_W'(sorted_keys.size());
      if (sorted_keys.size() > peak_occupancy)
         peak_occupancy = sorted_keys.size();
      return rep;
   endfunction

   // Percentage of idle cycles for one side in the current phase of the run.
   function automatic int gap_percent(input bit sender);
      case ((accepted_requests / PHASE_LENGTH) % 4)
         1: return sender ? 56 : 0;
         2: return sender ? 0 : 56;
         3: return 15;
         default: return 0;
      endcase
   endfunction

   task automatic queue_request(input action_type act, input key_type key);
      depq_request_type req;
      req.act = act;
      req.key = key;
      request_backlog.push_back(req);
      total_requests++;
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : driver
      depq_request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_reports.push_back(depq_update(req_action, req_key_in));
            accepted_requests <= accepted_requests + 1;
         end
         if (!req_valid || !req_stall) begin
            // The sender keeps offering requests during the long result hold-off.
            if (request_backlog.size() > 0 &&
                (hold_cycles != 0 || $urandom_range(99) >= gap_percent(1'b1))) begin
               next_req = request_backlog.pop_front();
               req_valid  <= 1'b1;
               req_action <= next_req.act;
               req_key_in <= next_req.key;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      depq_report_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_reports.size() == 0) begin
               $error("result arrived with no request outstanding");
               error_count++;
            end else begin
               want = pending_reports.pop_front();
               check_field("max_key", want.max_key, rsp_max_key);
               check_field("min_key", want.min_key, rsp_min_key);
               check_field("occupancy", 32'(want.occupancy), 32'(rsp_occupancy));
               check_field("removed_key", want.removed_key, rsp_removed_key);
               check_field("removed_valid", 32'(want.removed_valid),
                           32'(rsp_removed_valid));
               check_field("overflow", 32'(want.overflow), 32'(rsp_overflow));
            end
         end
         rsp_stall <= (hold_cycles != 0) || ($urandom_range(99) < gap_percent(1'b0));
      end
   end

   // One long stretch of result back-pressure so that the block fills and stalls requests.
   always @(posedge clock) begin
      if (reset) begin
         hold_cycles <= 0;
         hold_used   <= 1'b0;
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
      end else if (!hold_used && accepted_requests >= HOLD_START) begin
         hold_cycles <= HOLD_LENGTH;
         hold_used   <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** double_ended_priority_queue_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      int made;
      int seg_len;
      int seg_mode;
      int key_mode;
      int insert_pct;
      int roll;
      key_type key;
      action_type act;

      // Removals and a no-op request on an empty queue.
      queue_request(ACT_REMOVE_MAX, 32'sh0000_1234);
      queue_request(ACT_REMOVE_MIN, 32'sh7FFF_FFFF);
      queue_request(ACT_NONE, 32'sh8000_0000);
      // Extreme keys and duplicates.
      queue_request(ACT_INSERT, 32'sh7FFF_FFFF);
      queue_request(ACT_INSERT, 32'sh8000_0000);
      queue_request(ACT_INSERT, 32'sh0000_0000);
      queue_request(ACT_INSERT, -32'sd1);
      queue_request(ACT_INSERT, 32'sh8000_0000);
      queue_request(ACT_INSERT, 32'sh7FFF_FFFF);
      queue_request(ACT_INSERT, 32'sh0000_0001);
      queue_request(ACT_NONE, -32'sd1);
      queue_request(ACT_REMOVE_MAX, '0);
      queue_request(ACT_REMOVE_MIN, '0);
      queue_request(ACT_REMOVE_MAX, -32'sd1);
      queue_request(ACT_REMOVE_MIN, 32'sh5555_5555);
      queue_request(ACT_REMOVE_MIN, '0);
      queue_request(ACT_REMOVE_MAX, '0);
      queue_request(ACT_REMOVE_MAX, '0);
      queue_request(ACT_REMOVE_MAX, '0);
      queue_request(ACT_INSERT, 32'sh5555_5555);
      queue_request(ACT_INSERT, 32'shAAAA_AAAA);
      queue_request(ACT_REMOVE_MIN, -32'sd1);
      queue_request(ACT_REMOVE_MAX, '0);

      // Random segments that fill, drain or churn the queue with varied key sets.
      made = 0;
      while (made < RANDOM_COUNT) begin
         seg_len  = $urandom_range(20, 120);
         seg_mode = $urandom_range(0, 2);
         key_mode = $urandom_range(0, 2);
         insert_pct = (seg_mode == 0) ? 80 : (seg_mode == 1) ? 25 : 50;
         for (int i = 0; i < seg_len && made < RANDOM_COUNT; i++) begin
            roll = $urandom_range(99);
            if (roll < 3)
               act = ACT_NONE;
            else if (roll < 3 + insert_pct)
               act = ACT_INSERT;
            else if ($urandom_range(1) == 0)
               act = ACT_REMOVE_MAX;
            else
               act = ACT_REMOVE_MIN;
            case (key_mode)
               1: key = $signed($urandom_range(7)) - 4;
               2: begin
                  case ($urandom_range(4))
                     0: key = 32'sh7FFF_FFFF;
                     1: key = 32'sh8000_0000;
                     2: key = '0;
                     3: key = -32'sd1;
                     default: key = $urandom;
                  endcase
               end
               default: key = $urandom;
            endcase
            queue_request(act, key);
            made++;
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (accepted_requests < total_requests)
         @(posedge clock);
      while (pending_reports.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Covered %0d requests, peak occupancy %0d, %0d inserts dropped when full,",
               total_requests, peak_occupancy, dropped_inserts);
      $display("%0d removals on an empty queue, and a %0d-cycle result hold-off.",
               empty_removals, HOLD_LENGTH);
      if (error_count == 0) begin
         $display("** double_ended_priority_queue_unit: PASSED **");
      end else begin
         $display("** double_ended_priority_queue_unit: FAILED **");
      end
      $finish;
   end

endmodule
